// File: rtl/mmq_pkg.sv
package mmq_pkg;

   // configuration of the mailbox bank
   localparam int NUM_MESSAGES = 8;
   localparam int QUEUE_DEPTH  = 8;
   localparam int WORD_BITS    = 32;

   // field widths
   localparam int MODE_W     = 3;
   localparam int MSG_W      = 3;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int CNT_W      = 4;
   localparam int LEN_W      = 4;
   localparam int LEN_XW     = LEN_W + 1;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // derived storage geometry
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CTRL_AW     = (NUM_MESSAGES > 1) ? $clog2(NUM_MESSAGES) : 1;
   localparam int STORE_DEPTH = NUM_MESSAGES * QUEUE_DEPTH;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_SEND     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RECEIVE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STATUS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GET_RES  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REL_RES  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLR_FLAG = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BUSY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_MSG = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_LIMIT  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LENGTHS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_MASK     = 1'd1;

   // per-message control entry, held in the control memory
   typedef struct packed {
      logic [PTR_W-1:0] rptr;
      logic [PTR_W-1:0] wptr;
      logic [CNT_W-1:0] count;
      logic             ovf;
      logic             busy;
      logic             flag;
   } ctrl_type;

   // response fields decided in the update cycle
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                flag_value;
      logic                notify;
      logic [CNT_W-1:0]    queue_count;
      logic                use_data;
   } result_type;

   // effective queue length of a message, clamped to the queue depth
   function automatic logic [LEN_W-1:0] length_of(input logic [CSR_DATA_W-1:0] lengths,
                                                  input logic [MSG_W-1:0] id);
      logic [LEN_W-1:0] nib;
      nib = lengths[id*LEN_W +: LEN_W];
      return (nib > LEN_W'(QUEUE_DEPTH)) ? LEN_W'(QUEUE_DEPTH) : nib;
   endfunction

   // circular pointer step with wrap at the current length
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [LEN_W-1:0] len);
      logic [LEN_XW-1:0] nxt;
      nxt = LEN_XW'(ptr) + LEN_XW'(1);
      return (nxt >= LEN_XW'(len)) ? '0 : PTR_W'(nxt);
   endfunction

   // store word address of a message slot
   function automatic logic [STORE_AW-1:0] slot_addr(input logic [MSG_W-1:0] id,
                                                     input logic [PTR_W-1:0] ptr);
      return STORE_AW'(STORE_AW'(id) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(ptr));
   endfunction

endpackage

// File: rtl/mmq_if.sv
interface mmq_req_if;
   import mmq_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [MSG_W-1:0]  msg_id;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, output mode, output msg_id, output data_in, input ready);
   modport sink   (input valid, input mode, input msg_id, input data_in, output ready);
endinterface

interface mmq_rsp_if;
   import mmq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   data_out;
   logic                flag_value;
   logic                notify;
   logic [CNT_W-1:0]    queue_count;

   modport source (output valid, output status, output data_out, output flag_value,
                   output notify, output queue_count, input ready);
   modport sink   (input valid, input status, input data_out, input flag_value,
                   input notify, input queue_count, output ready);
endinterface

// File: rtl/message_mailbox_queue_core.sv
// Bank of eight message mailboxes, each an overwrite slot (length nibble 0) or a
// circular queue of up to eight words, with busy guards and notify flags. Every
// request goes through accept and read of the message's control entry, one
// read-modify-write of that entry together with the message word store, then the
// load of the response register, which waits while an earlier response is not
// yet taken. Control memory and word store have registered reads; a new request
// is taken once the response is loaded, even while it waits to be taken. Control
// entries carry valid bits, so no clearing pass follows reset; the word store is
// not initialized and a read of a never-written word returns arbitrary data.
// Configuration writes are taken on any cycle and must only occur while idle.
module message_mailbox_queue_core (
   input  logic                               clock,
   input  logic                               reset,
   mmq_req_if.sink                            req_if,
   mmq_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [mmq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mmq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mmq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CTRL = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CSR_DATA_W-1:0]   qlen_ff;
   logic [MASK_W-1:0]       mask_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [MSG_W-1:0]        id_ff;
   logic [DATA_W-1:0]       data_ff;
   logic [NUM_MESSAGES-1:0] vld_ff, vld_in;
   result_type              res_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [DATA_W-1:0]       rsp_data_ff;
   logic                    rsp_flag_ff;
   logic                    rsp_notify_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic                    accept;
   logic                    id_ok;
   logic [CTRL_AW-1:0]      ctrl_idx;
   logic [$bits(ctrl_type)-1:0] ctrl_rd;
   ctrl_type                cur, nxt;
   logic                    ctrl_we, st_we, st_re;
   logic [PTR_W-1:0]        st_ptr;
   logic [STORE_AW-1:0]     st_addr;
   logic [WORD_BITS-1:0]    st_rd;
   result_type              res;
   logic                    out_free;
   logic                    in_ctrl;

   assign accept   = req_if.valid && req_if.ready;
   assign in_ctrl  = (state_ff == ST_CTRL);
   assign id_ok    = ({1'b0, id_ff} < (MSG_W + 1)'(NUM_MESSAGES));
   assign ctrl_idx = CTRL_AW'(id_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff <= '0;
         mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUEUE_LENGTHS: qlen_ff <= csr_wdata;
            CSR_FLAG_MASK:     mask_ff <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_if.mode;
         id_ff   <= req_if.msg_id;
         data_ff <= req_if.data_in;
      end
   end

   // control entries: memory plus valid bits, an unwritten entry reads as zero
   mmq_ram #(
      .WIDTH ($bits(ctrl_type)),
      .DEPTH (NUM_MESSAGES)
   ) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (in_ctrl && ctrl_we),
      .wr_addr (ctrl_idx),
      .wr_data (nxt),
      .rd_en   (accept),
      .rd_addr (CTRL_AW'(req_if.msg_id)),
      .rd_data (ctrl_rd)
   );

   assign cur = (id_ok && vld_ff[ctrl_idx]) ? ctrl_type'(ctrl_rd) : '0;

   always_comb begin
      vld_in = vld_ff;
      if (in_ctrl && ctrl_we) begin
         vld_in[ctrl_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // per-request update
   mmq_step u_step (
      .mode     (mode_ff),
      .id_ok    (id_ok),
      .len      (length_of(qlen_ff, id_ff)),
      .mask_bit (mask_ff[id_ff]),
      .cur      (cur),
      .nxt      (nxt),
      .ctrl_we  (ctrl_we),
      .st_we    (st_we),
      .st_re    (st_re),
      .st_ptr   (st_ptr),
      .res      (res)
   );

   // message word store
   assign st_addr = slot_addr(id_ff, st_ptr);

   mmq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (in_ctrl && st_we),
      .wr_addr (st_addr),
      .wr_data (WORD_BITS'(data_ff)),
      .rd_en   (in_ctrl && st_re),
      .rd_addr (st_addr),
      .rd_data (st_rd)
   );

   always_ff @(posedge clock) begin
      if (in_ctrl) begin
         res_ff <= res;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CTRL;
         ST_CTRL: state_in = ST_PUSH;
         ST_PUSH: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (state_ff == ST_PUSH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PUSH && out_free) begin
         rsp_status_ff <= res_ff.status;
         rsp_data_ff   <= res_ff.use_data ? DATA_W'(st_rd) : '0;
         rsp_flag_ff   <= res_ff.flag_value;
         rsp_notify_ff <= res_ff.notify;
         rsp_count_ff  <= res_ff.queue_count;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.data_out    = rsp_data_ff;
   assign rsp_if.flag_value  = rsp_flag_ff;
   assign rsp_if.notify      = rsp_notify_ff;
   assign rsp_if.queue_count = rsp_count_ff;

   // checks
   a_accept_to_ctrl: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CTRL)
      else $error("accepted request did not enter the update cycle");

   a_store_write_in_ctrl: assert property (@(posedge clock) disable iff (reset)
      (st_we && in_ctrl) |-> (id_ok && mode_ff == MODE_SEND))
      else $error("store written outside a send");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUSH)
      else $error("response raised without a finished request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond queue depth");
endmodule

// File: rtl/mmq_ram.sv
module mmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read that holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/mmq_step.sv
module mmq_step (
   input  logic [mmq_pkg::MODE_W-1:0] mode,
   input  logic                       id_ok,
   input  logic [mmq_pkg::LEN_W-1:0]  len,
   input  logic                       mask_bit,
   input  mmq_pkg::ctrl_type          cur,
   output mmq_pkg::ctrl_type          nxt,
   output logic                       ctrl_we,
   output logic                       st_we,
   output logic                       st_re,
   output logic [mmq_pkg::PTR_W-1:0]  st_ptr,
   output mmq_pkg::result_type        res
);
   import mmq_pkg::*;

   // decide the new control entry, store access and response for one request
   always_comb begin
      nxt     = cur;
      ctrl_we = 1'b0;
      st_we   = 1'b0;
      st_re   = 1'b0;
      st_ptr  = '0;
      res     = '0;
      if (id_ok) begin
         ctrl_we = 1'b1;
         unique case (mode)
            MODE_SEND: begin
               if (len == '0) begin
                  st_we = 1'b1;
               end else if (cur.count >= CNT_W'(len)) begin
                  nxt.ovf = 1'b1;
               end else begin
                  st_we     = 1'b1;
                  st_ptr    = cur.wptr;
                  nxt.wptr  = advance(cur.wptr, len);
                  nxt.count = cur.count + CNT_W'(1);
               end
               if (mask_bit) begin
                  nxt.flag = 1'b1;
               end else begin
                  res.notify = 1'b1;
               end
            end
            MODE_RECEIVE: begin
               if (len == '0) begin
                  st_re        = 1'b1;
                  res.use_data = 1'b1;
               end else if (cur.count == '0) begin
                  res.status = STAT_NO_MSG;
               end else begin
                  if (cur.ovf) begin
                     res.status = STAT_LIMIT;
                     nxt.ovf    = 1'b0;
                  end
                  st_re        = 1'b1;
                  res.use_data = 1'b1;
                  st_ptr       = cur.rptr;
                  nxt.rptr     = advance(cur.rptr, len);
                  nxt.count    = cur.count - CNT_W'(1);
               end
            end
            MODE_STATUS: begin
               if (cur.busy) begin
                  res.status = STAT_BUSY;
               end else if (len != '0 && cur.count == '0) begin
                  res.status = STAT_NO_MSG;
               end else if (len != '0 && cur.ovf) begin
                  res.status = STAT_LIMIT;
               end
            end
            MODE_GET_RES: begin
               if (cur.busy) begin
                  res.status = STAT_BUSY;
               end else begin
                  nxt.busy = 1'b1;
               end
            end
            MODE_REL_RES: begin
               nxt.busy = 1'b0;
            end
            MODE_CLR_FLAG: begin
               nxt.flag = 1'b0;
            end
            default: begin
            end
         endcase
         res.flag_value  = nxt.flag;
         res.queue_count = nxt.count;
      end
   end
endmodule

// File: sim/message_mailbox_queue_checker.sv
`timescale 1ns / 1ps
module message_mailbox_queue_checker (
   input  logic                           clock,
   input  logic                           reset,
   mmq_req_if                             req_mon,
   mmq_rsp_if                             rsp_mon,
   input  logic                           csr_we,
   input  logic [mmq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mmq_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             checked
);
   import mmq_pkg::*;

   // one predicted response
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_out;
      logic                flag_value;
      logic                notify;
      logic [CNT_W-1:0]    queue_count;
   } mailbox_answer_type;

   // shadow of the mailbox bank
   logic [DATA_W-1:0] word_store [STORE_DEPTH];
   logic [PTR_W-1:0]  rd_ptr     [NUM_MESSAGES];
   logic [PTR_W-1:0]  wr_ptr     [NUM_MESSAGES];
   logic [CNT_W-1:0]  held       [NUM_MESSAGES];
   logic              overflow   [NUM_MESSAGES];
   logic              busy       [NUM_MESSAGES];
   logic              flagged    [NUM_MESSAGES];

   // shadow of the registers
   logic [CSR_DATA_W-1:0] lengths_cfg;
   logic [MASK_W-1:0]     mask_cfg;

   mailbox_answer_type answer_q [$];

   // queue length of a message, large nibbles clamp to the depth
   function automatic int effective_len(input logic [MSG_W-1:0] id);
      int nib;
      nib = int'(lengths_cfg[int'(id)*LEN_W +: LEN_W]);
      return (nib > QUEUE_DEPTH) ? QUEUE_DEPTH : nib;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p, input int len);
      return (int'(p) + 1 >= len) ? '0 : PTR_W'(int'(p) + 1);
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatches < 100) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // apply one request to the shadow and queue the response it should produce
   task automatic predict_request(input logic [MODE_W-1:0] mode, input logic [MSG_W-1:0] id,
                                  input logic [DATA_W-1:0] word);
      mailbox_answer_type ans;
      int len;
      int base;
      ans = '0;
      if (int'(id) >= NUM_MESSAGES) begin
         answer_q.push_back(ans);
         return;
      end
      len = effective_len(id);
      base = int'(id) * QUEUE_DEPTH;
      case (mode)
         MODE_SEND: begin
            if (len == 0) begin
               word_store[base] = word;
            end else if (int'(held[id]) >= len) begin
               overflow[id] = 1'b1;
            end else begin
               word_store[base + int'(wr_ptr[id])] = word;
               wr_ptr[id] = next_ptr(wr_ptr[id], len);
               held[id] = held[id] + 1'b1;
            end
            if (mask_cfg[id]) flagged[id] = 1'b1;
            else ans.notify = 1'b1;
         end
         MODE_RECEIVE: begin
            if (len == 0) begin
               ans.data_out = word_store[base];
            end else if (held[id] == '0) begin
               ans.status = STAT_NO_MSG;
            end else begin
               // a pending overflow is reported once, the word still leaves
               if (overflow[id]) begin
                  ans.status = STAT_LIMIT;
                  overflow[id] = 1'b0;
               end
               ans.data_out = word_store[base + int'(rd_ptr[id])];
               rd_ptr[id] = next_ptr(rd_ptr[id], len);
               held[id] = held[id] - 1'b1;
            end
         end
         MODE_STATUS: begin
            if (busy[id]) ans.status = STAT_BUSY;
            else if (len != 0 && held[id] == '0) ans.status = STAT_NO_MSG;
            else if (len != 0 && overflow[id]) ans.status = STAT_LIMIT;
         end
         MODE_GET_RES: begin
            if (busy[id]) ans.status = STAT_BUSY;
            else busy[id] = 1'b1;
         end
         MODE_REL_RES: begin
            busy[id] = 1'b0;
         end
         MODE_CLR_FLAG: begin
            flagged[id] = 1'b0;
         end
         default: begin
         end
      endcase
      ans.flag_value = flagged[id];
      ans.queue_count = held[id];
      answer_q.push_back(ans);
   endtask

   // watch registers and both channels, compare in order
   always @(posedge clock) begin
      mailbox_answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_MESSAGES; i++) begin
            rd_ptr[i] = '0;
            wr_ptr[i] = '0;
            held[i] = '0;
            overflow[i] = 1'b0;
            busy[i] = 1'b0;
            flagged[i] = 1'b0;
         end
         lengths_cfg = '0;
         mask_cfg = '0;
         answer_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_QUEUE_LENGTHS) lengths_cfg = csr_wdata;
            else if (csr_index == CSR_FLAG_MASK) mask_cfg = csr_wdata[MASK_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.mode, req_mon.msg_id, req_mon.data_in);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unrequested response data", rsp_mon.data_out, '0);
            end else begin
               want = answer_q.pop_front();
               checked++;
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_mon.status), DATA_W'(want.status));
               if (rsp_mon.data_out !== want.data_out)
                  report_mismatch("data_out", rsp_mon.data_out, want.data_out);
               if (rsp_mon.flag_value !== want.flag_value)
                  report_mismatch("flag_value", DATA_W'(rsp_mon.flag_value),
                                  DATA_W'(want.flag_value));
               if (rsp_mon.notify !== want.notify)
                  report_mismatch("notify", DATA_W'(rsp_mon.notify), DATA_W'(want.notify));
               if (rsp_mon.queue_count !== want.queue_count)
                  report_mismatch("queue_count", DATA_W'(rsp_mon.queue_count),
                                  DATA_W'(want.queue_count));
            end
         end
      end
      outstanding <= answer_q.size();
   end

endmodule

// File: sim/message_mailbox_queue_core_tb.sv
`timescale 1ns / 1ps
module message_mailbox_queue_core_tb;
   import mmq_pkg::*;

   // the two modes the block leaves unused
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   int                    requests_sent;
   int                    reg_writes;
   int                    mismatches;
   int                    outstanding;
   int                    checked;

   mmq_req_if req_if();
   mmq_rsp_if rsp_if();

   message_mailbox_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   message_mailbox_queue_checker mmq_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // one request, with random sender gaps before it
   task automatic push_request(input logic [MODE_W-1:0] mode, input logic [MSG_W-1:0] id,
                               input logic [DATA_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= mode;
      req_if.msg_id <= id;
      req_if.data_in <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
   endtask

   // stop sending and let every response drain
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // length nibbles favoring short queues, with slots, full depth and clamped values
   function automatic logic [CSR_DATA_W-1:0] pick_lengths();
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      for (int i = 0; i < NUM_MESSAGES; i++) begin
         case ($urandom_range(5))
            0: v[i*LEN_W +: LEN_W] = LEN_W'(0);
            1: v[i*LEN_W +: LEN_W] = LEN_W'(1);
            2: v[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(2, 4));
            3: v[i*LEN_W +: LEN_W] = LEN_W'(QUEUE_DEPTH);
            4: v[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(QUEUE_DEPTH + 1, 15));
            default: v[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(15));
         endcase
      end
      return v;
   endfunction

   // random request, send share set by the caller to fill or drain queues
   task automatic random_request(input int send_w, input logic [MSG_W-1:0] hot);
      int r;
      logic [MODE_W-1:0] mode;
      logic [MSG_W-1:0] id;
      r = $urandom_range(99);
      if (r < send_w) mode = MODE_SEND;
      else if (r < 70) mode = MODE_RECEIVE;
      else if (r < 78) mode = MODE_STATUS;
      else if (r < 85) mode = MODE_GET_RES;
      else if (r < 91) mode = MODE_REL_RES;
      else if (r < 97) mode = MODE_CLR_FLAG;
      else mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
      id = $urandom_range(1) ? hot : MSG_W'($urandom_range(NUM_MESSAGES - 1));
      push_request(mode, id, DATA_W'($urandom));
   endtask

   initial begin
      int sel;
      int send_w;
      int drain_wait;
      logic [MSG_W-1:0] hot;
      logic [CSR_DATA_W-1:0] lengths;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.mode <= '0;
      req_if.msg_id <= '0;
      req_if.data_in <= '0;
      send_idle_pct = 38;
      recv_idle_pct = 67;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // preload: fill every queue word once at full depth, then drain it
      write_reg(CSR_QUEUE_LENGTHS, {NUM_MESSAGES{LEN_W'(QUEUE_DEPTH)}});
      write_reg(CSR_FLAG_MASK, '0);
      for (int m = 0; m < NUM_MESSAGES; m++) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) push_request(MODE_SEND, MSG_W'(m), $urandom);
         for (int k = 0; k < QUEUE_DEPTH; k++) push_request(MODE_RECEIVE, MSG_W'(m), '0);
      end
      settle();

      // directed: slot overwrite, single-entry queue with overflow, busy guard, flags
      write_reg(CSR_QUEUE_LENGTHS, 32'hF000_2010);
      write_reg(CSR_FLAG_MASK, 32'h0000_0002);
      push_request(MODE_SEND, 3'd0, 32'hFFFF_FFFF);
      push_request(MODE_RECEIVE, 3'd0, '0);
      push_request(MODE_SEND, 3'd0, 32'h0000_0000);
      push_request(MODE_RECEIVE, 3'd0, 32'hFFFF_FFFF);
      push_request(MODE_STATUS, 3'd0, '0);
      push_request(MODE_SEND, 3'd1, 32'hA5A5_5A5A);
      push_request(MODE_SEND, 3'd1, 32'h5A5A_A5A5);
      push_request(MODE_STATUS, 3'd1, '0);
      push_request(MODE_RECEIVE, 3'd1, '0);
      push_request(MODE_RECEIVE, 3'd1, '0);
      push_request(MODE_STATUS, 3'd1, '0);
      push_request(MODE_GET_RES, 3'd1, '0);
      push_request(MODE_GET_RES, 3'd1, '0);
      push_request(MODE_STATUS, 3'd1, '0);
      push_request(MODE_SEND, 3'd1, 32'h1234_5678);
      push_request(MODE_RECEIVE, 3'd1, '0);
      push_request(MODE_REL_RES, 3'd1, '0);
      push_request(MODE_CLR_FLAG, 3'd1, '0);
      push_request(MODE_SPARE_LO, 3'd7, 32'hFFFF_FFFF);
      push_request(MODE_SPARE_HI, 3'd7, '0);
      push_request(MODE_STATUS, 3'd7, '0);
      push_request(MODE_SEND, 3'd3, 32'h8000_0001);
      push_request(MODE_STATUS, 3'd3, '0);

      // random traffic in three pacing profiles, register changes between blocks
      for (int ph = 0; ph < 3; ph++) begin
         for (int blk = 0; blk < 4; blk++) begin
            settle();
            if (blk == 0) begin
               send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 67 : 0;
               recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 38 : 0;
            end
            sel = ph * 4 + blk;
            lengths = (sel == 0) ? '0 : (sel == 1) ? '1 : pick_lengths();
            write_reg(CSR_QUEUE_LENGTHS, lengths);
            write_reg(CSR_FLAG_MASK, (sel == 0) ? CSR_DATA_W'(8'hFF) :
                                     (sel == 1) ? '0 : CSR_DATA_W'($urandom_range(255)));
            send_w = 45;
            hot = '0;
            for (int n = 0; n < 140; n++) begin
               if (n % 25 == 0) begin
                  case ($urandom_range(2))
                     0: send_w = 25;
                     1: send_w = 45;
                     default: send_w = 62;
                  endcase
                  hot = MSG_W'($urandom_range(NUM_MESSAGES - 1));
               end
               random_request(send_w, hot);
            end
         end
      end

      // wait out the remaining responses
      req_if.valid <= 1'b0;
      @(posedge clock);
      drain_wait = 0;
      while (outstanding != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);

      $display("covered %0d requests and %0d register writes, %0d responses compared",
               requests_sent, reg_writes, checked);
      $display("pacing: sender-heavy, receiver-heavy and back-to-back idle profiles");
      if (outstanding != 0) begin
         $display("%0d expected responses never arrived", outstanding);
      end
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/mmq_pkg.sv
rtl/mmq_if.sv
rtl/mmq_ram.sv
rtl/mmq_step.sv
rtl/message_mailbox_queue_core.sv
sim/message_mailbox_queue_checker.sv
sim/message_mailbox_queue_core_tb.sv
